### rtl/hwnld_pkg.sv
// Package for the wrapped-normal log density core.
// Holds the field widths, fixed-point constants, controller states and the
// command and status structs shared by the controller and the datapath.
`default_nettype none
package hwnld_pkg;

    localparam int MAX_DIM_DEF = 64;
    localparam int VAL_W       = 16;
    localparam int SIG_W       = 15;
    localparam int CURV_W      = 16;
    localparam int RES_W       = 32;
    localparam int DCNT_W      = 7;
    localparam int WSUM_W      = 48;
    localparam int NSUM_W      = 40;
    localparam int DEN_W       = 37;
    localparam int MAN_W       = 31;
    localparam int LOG_W       = 22;
    localparam int ITER_W      = 6;
    localparam int DIV_STEPS   = 48;
    localparam int LOG_STEPS   = 16;

    localparam logic [CURV_W-1:0] CURV_RESET = 16'd4096;
    localparam logic [DEN_W-1:0]  ONE_Q36    = 37'h10_0000_0000;
    localparam logic [DEN_W-1:0]  DENOM_MIN  = 37'd6871948;
    localparam logic [31:0]       LN2_Q32    = 32'd2977044472;
    localparam logic [LOG_W-1:0]  LOG2_TOP   = 22'd2424832;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DEN,
        ST_NORM,
        ST_LOG_INIT,
        ST_SQ,
        ST_CMP,
        ST_LN,
        ST_SCALE,
        ST_RES
    } t_state;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       acc;
        logic       mul_lo;
        logic       mul_hi;
        logic       sum;
        logic       den;
        logic       norm_step;
        logic       log_init;
        logic       sq;
        logic       cmp;
        logic [3:0] bit_idx;
        logic       ln;
        logic       scale;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic m_top;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

### rtl/hyperbolic_wrapped_normal_log_density_core.sv
// Top level of the wrapped-normal log density core on the Poincare ball.
// An item passes through the load and the bit-serial divider to accumulation;
// the last item of a vector goes on through the curvature product,
// normalization, the 16-step log2 squaring loop and the output register, where
// it also waits while the previous result is held by i_stall. o_stall is high
// until the core is idle again, so no new item is taken before then. Synchronous
// active-low reset clears the sums and sets curvature to 1.0.
`default_nettype none
module hyperbolic_wrapped_normal_log_density_core #(
    parameter int MAX_DIM = hwnld_pkg::MAX_DIM_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [hwnld_pkg::CURV_W-1:0]       i_cfg_data,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  signed [hwnld_pkg::VAL_W-1:0] i_point_value,
    input  wire  signed [hwnld_pkg::VAL_W-1:0] i_mean_value,
    input  wire  [hwnld_pkg::SIG_W-1:0]        i_std_dev,
    input  wire                                i_last_element,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic signed [hwnld_pkg::RES_W-1:0] o_log_density,
    output logic                               o_saturated,
    output logic [hwnld_pkg::DCNT_W-1:0]       o_dim_count
);
    import hwnld_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    hwnld_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    hwnld_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_point_value  (i_point_value),
        .i_mean_value   (i_mean_value),
        .i_std_dev      (i_std_dev),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_log_density  (o_log_density),
        .o_saturated    (o_saturated),
        .o_dim_count    (o_dim_count)
    );

endmodule
`default_nettype wire

### rtl/hwnld_ctrl.sv
// Controller state machine for the wrapped-normal log density core.
// Sequences the divider, accumulation and log iteration; uses hwnld_pkg.
`default_nettype none
module hwnld_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  hwnld_pkg::t_status i_status,
    output hwnld_pkg::t_cmd    o_cmd
);
    import hwnld_pkg::*;

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_iter     = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_iter == ITER_W'(DIV_STEPS - 1)) begin
                    n_state = ST_ACC;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.last ? ST_MUL_LO : ST_IDLE;
            end
            ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_DEN;
            end
            ST_DEN: begin
                o_cmd.den = 1'b1;
                n_state   = ST_NORM;
            end
            ST_NORM: begin
                if (i_status.m_top) begin
                    n_state = ST_LOG_INIT;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            ST_LOG_INIT: begin
                o_cmd.log_init = 1'b1;
                n_iter         = '0;
                n_state        = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp     = 1'b1;
                o_cmd.bit_idx = 4'(LOG_STEPS - 1) - r_iter[3:0];
                if (r_iter == ITER_W'(LOG_STEPS - 1)) begin
                    n_state = ST_LN;
                end else begin
                    n_iter  = r_iter + 1'b1;
                    n_state = ST_SQ;
                end
            end
            ST_LN: begin
                o_cmd.ln = 1'b1;
                n_state  = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_RES;
            end
            ST_RES: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/hwnld_dp.sv
// Datapath for the wrapped-normal log density core: divider, sums,
// curvature product, log2 iteration and output register; uses hwnld_pkg.
`default_nettype none
module hwnld_dp #(
    parameter int MAX_DIM = hwnld_pkg::MAX_DIM_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  hwnld_pkg::t_cmd                      i_cmd,
    output hwnld_pkg::t_status                   o_status,
    input  wire                                  i_cfg_we,
    input  wire  [hwnld_pkg::CURV_W-1:0]         i_cfg_data,
    input  wire  signed [hwnld_pkg::VAL_W-1:0]   i_point_value,
    input  wire  signed [hwnld_pkg::VAL_W-1:0]   i_mean_value,
    input  wire  [hwnld_pkg::SIG_W-1:0]          i_std_dev,
    input  wire                                  i_last_element,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic signed [hwnld_pkg::RES_W-1:0]   o_log_density,
    output logic                                 o_saturated,
    output logic [hwnld_pkg::DCNT_W-1:0]         o_dim_count
);
    import hwnld_pkg::*;

    localparam int CW  = $clog2(MAX_DIM + 1);
    localparam int SCW = CW + LOG_W;
    localparam int SW  = ((SCW > WSUM_W - 1) ? SCW : WSUM_W - 1) + 2;

    logic [CURV_W-1:0]       r_curv;
    logic [WSUM_W-1:0]       r_num;
    logic [2*SIG_W-1:0]      r_den;
    logic [2*SIG_W:0]        r_rem;
    logic [31:0]             r_zz;
    logic                    r_last;
    logic [WSUM_W-1:0]       r_wsum;
    logic [NSUM_W-1:0]       r_nsum;
    logic [CW-1:0]           r_cnt;
    logic                    r_clip;
    logic [35:0]             r_plo;
    logic [35:0]             r_phi;
    logic [55:0]             r_prod;
    logic [DEN_W-1:0]        r_m;
    logic [5:0]              r_msb;
    logic [MAN_W-1:0]        r_man;
    logic [2*MAN_W-1:0]      r_sq;
    logic [LOG_W-1:0]        r_log;
    logic [LOG_W-1:0]        r_ln;
    logic [SCW-1:0]          r_scaled;
    logic                    r_out_valid;
    logic signed [RES_W-1:0] r_out_res;
    logic                    r_out_sat;
    logic [DCNT_W-1:0]       r_out_cnt;

    logic signed [VAL_W:0]   d;
    logic [VAL_W-1:0]        ad;
    logic [SIG_W-1:0]        sig;
    logic signed [31:0]      zsq;
    logic [2*SIG_W+1:0]      rem_sh;
    logic [2*SIG_W+1:0]      rem_sub;
    logic [WSUM_W:0]         wadd;
    logic [NSUM_W:0]         nadd;
    logic [56:0]             den_diff;
    logic [MAN_W:0]          sq_top;
    logic [LOG_W-1:0]        l2lam;
    logic [LOG_W+31:0]       lnp;
    logic signed [SW-1:0]    res;
    logic [CW+DCNT_W-1:0]    cnt_ext;
    logic                    out_free;

    assign d        = i_point_value - i_mean_value;
    assign ad       = d[VAL_W] ? VAL_W'(-d) : d[VAL_W-1:0];
    assign sig      = (i_std_dev == '0) ? SIG_W'(1) : i_std_dev;
    assign zsq      = i_point_value * i_point_value;
    assign rem_sh   = {r_rem, r_num[WSUM_W-1]};
    assign rem_sub  = rem_sh - {2'b00, r_den};
    assign wadd     = {1'b0, r_wsum} + {1'b0, r_num};
    assign nadd     = {1'b0, r_nsum} + {(NSUM_W + 1 - 32)'(0), r_zz};
    assign den_diff = {20'd0, ONE_Q36} - {1'b0, r_prod};
    assign sq_top   = r_sq[2*MAN_W-1:MAN_W-1];
    assign l2lam    = LOG2_TOP - r_log;
    assign lnp      = l2lam * LN2_Q32 + {LOG_W'(0), 31'h4000_0000, 1'b0};
    assign res      = $signed({2'b00, {(SW - 2 - SCW)'(0)}, r_scaled})
                    - $signed({(SW - WSUM_W + 1)'(0), r_wsum[WSUM_W-1:1]});
    assign cnt_ext  = {{DCNT_W{1'b0}}, r_cnt};
    assign out_free = !r_out_valid || !i_stall;

    assign o_status.last     = r_last;
    assign o_status.m_top    = r_m[DEN_W-1];
    assign o_status.out_free = out_free;

    assign o_valid       = r_out_valid;
    assign o_log_density = r_out_res;
    assign o_saturated   = r_out_sat;
    assign o_dim_count   = r_out_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curv      <= CURV_RESET;
            r_wsum      <= '0;
            r_nsum      <= '0;
            r_cnt       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_curv <= i_cfg_data;
            end
            if (i_cmd.acc) begin
                if (r_cnt < CW'(MAX_DIM)) begin
                    r_wsum <= wadd[WSUM_W] ? '1 : wadd[WSUM_W-1:0];
                    r_nsum <= nadd[NSUM_W] ? '1 : nadd[NSUM_W-1:0];
                    r_cnt  <= r_cnt + 1'b1;
                    if (wadd[WSUM_W] || nadd[NSUM_W]) begin
                        r_clip <= 1'b1;
                    end
                end else begin
                    r_clip <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_wsum      <= '0;
                r_nsum      <= '0;
                r_cnt       <= '0;
                r_clip      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num  <= {(2*VAL_W)'(ad) * (2*VAL_W)'(ad), 16'd0};
            r_den  <= sig * sig;
            r_rem  <= '0;
            r_zz   <= zsq;
            r_last <= i_last_element;
        end
        if (i_cmd.div_step) begin
            if (!rem_sub[2*SIG_W+1]) begin
                r_rem <= rem_sub[2*SIG_W:0];
                r_num <= {r_num[WSUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[2*SIG_W:0];
                r_num <= {r_num[WSUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.mul_lo) begin
            r_plo <= r_curv * r_nsum[19:0];
        end
        if (i_cmd.mul_hi) begin
            r_phi <= r_curv * r_nsum[NSUM_W-1:20];
        end
        if (i_cmd.sum) begin
            r_prod <= {20'd0, r_plo} + {r_phi, 20'd0};
        end
        if (i_cmd.den) begin
            r_msb <= 6'd36;
            if (den_diff[56] || den_diff[DEN_W-1:0] < DENOM_MIN) begin
                r_m <= DENOM_MIN;
            end else begin
                r_m <= den_diff[DEN_W-1:0];
            end
        end
        if (i_cmd.norm_step) begin
            r_m   <= {r_m[DEN_W-2:0], 1'b0};
            r_msb <= r_msb - 1'b1;
        end
        if (i_cmd.log_init) begin
            r_man <= r_m[DEN_W-1:DEN_W-MAN_W];
            r_log <= {r_msb, 16'd0};
        end
        if (i_cmd.sq) begin
            r_sq <= r_man * r_man;
        end
        if (i_cmd.cmp) begin
            if (sq_top[MAN_W]) begin
                r_man               <= sq_top[MAN_W:1];
                r_log[i_cmd.bit_idx] <= 1'b1;
            end else begin
                r_man <= sq_top[MAN_W-1:0];
            end
        end
        if (i_cmd.ln) begin
            r_ln <= lnp[LOG_W+31:32];
        end
        if (i_cmd.scale) begin
            r_scaled <= r_cnt * r_ln;
        end
        if (i_cmd.finish) begin
            r_out_cnt <= cnt_ext[DCNT_W-1:0];
            if (res > SW'(32'sh7FFF_FFFF)) begin
                r_out_res <= 32'sh7FFF_FFFF;
                r_out_sat <= 1'b1;
            end else if (res < -SW'(33'sh0_8000_0000)) begin
                r_out_res <= 32'sh8000_0000;
                r_out_sat <= 1'b1;
            end else begin
                r_out_res <= res[RES_W-1:0];
                r_out_sat <= r_clip;
            end
        end
    end

endmodule
`default_nettype wire
